>>> sv/bctm_pkg.sv
// ----------------------------------------------------------------------------
// bctm_pkg
// Shared widths, constants, register indexes and the sequencer program of
// the battery charge and thermal model.
// ----------------------------------------------------------------------------
package bctm_pkg;

   localparam int unsigned STEP_W     = 20;
   localparam int unsigned VOLT_W     = 16;
   localparam int unsigned GAIN_W     = 12;
   localparam int unsigned LEVEL_W    = 23;
   localparam int unsigned LOAD_W     = 7;
   localparam int unsigned ID_W       = 10;
   localparam int unsigned PAYLOAD_W  = 64;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 20;

   // shared multiplier: signed operands, registered product
   localparam int unsigned MUL_W  = 33;
   localparam int unsigned PROD_W = 2 * MUL_W;

   // floor(x / 100) = (x * RECIP) >> QUOT_LSB, exact for x below 2^32
   localparam logic [31:0] RECIP    = 32'd2748779070;
   localparam int unsigned QUOT_LSB = 38;
   localparam int unsigned DRAIN_W  = 26;
   localparam int unsigned HEAT_W   = 21;
   localparam int unsigned TEN_LSB  = 16;

   // 100 * 2^23 keeps the scaled voltage numerator positive; low 16 bits are 0
   localparam logic [31:0] VOLT_BIAS = 32'd838860800;

   typedef logic [LEVEL_W-1:0] level_type;

   localparam level_type SOC_FULL  = 23'd6553600;
   localparam level_type TEMP_MIN  = 23'd983040;
   localparam level_type TEMP_COOL = 23'd1310720;
   localparam level_type TEMP_INIT = 23'd1638400;
   localparam level_type TEMP_MAX  = 23'd5242880;

   localparam logic [ID_W-1:0] ID_STATUS = 10'h301;
   localparam logic [ID_W-1:0] ID_TEMP   = 10'h302;
   localparam logic [ID_W-1:0] ID_VOLT   = 10'h303;

   localparam logic [7:0] LOAD_MAX = 8'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHARGE_STEP,
      CSR_DRAIN_STEP,
      CSR_COOL_STEP,
      CSR_HEAT_STEP,
      CSR_VOLT_FLOOR,
      CSR_VOLT_CEILING,
      CSR_FAULT_GAIN,
      CSR_FAULT_ON
   } csr_index_type;

   localparam logic [STEP_W-1:0] CHARGE_STEP_RST = 20'd3277;
   localparam logic [STEP_W-1:0] DRAIN_STEP_RST  = 20'd1311;
   localparam logic [STEP_W-1:0] COOL_STEP_RST   = 20'd3277;
   localparam logic [STEP_W-1:0] HEAT_STEP_RST   = 20'd6554;
   localparam logic [VOLT_W-1:0] VOLT_FLOOR_RST  = 16'd2800;
   localparam logic [VOLT_W-1:0] VOLT_CEIL_RST   = 16'd4200;
   localparam logic [GAIN_W-1:0] GAIN_UNITY      = 12'd256;

   // ---- sequencer control word ----
   typedef enum logic [2:0] {
      A_DRAIN,     // drain_step
      A_PROD_LOW,  // low 28 bits of the product
      A_SCALED,    // product >> 8
      A_HEAT,      // heat_step
      A_DIFF,      // volt_ceiling - volt_floor, signed
      A_BIASED,    // (product >>> 16) + bias
      A_TEMP       // cell temperature
   } a_sel_type;

   typedef enum logic [2:0] {
      B_LOAD100,   // 100 + load
      B_GAIN,      // drain multiplier
      B_RECIP,     // reciprocal of 100
      B_LOAD1,     // load + 1
      B_SOC,       // charge level
      B_TEN
   } b_sel_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_SAVE_DRAIN,
      ACT_DISCHARGE,
      ACT_CHARGE,
      ACT_SAVE_VOLT,
      ACT_EMIT_STATUS,
      ACT_EMIT_TEMP,
      ACT_EMIT_VOLT
   } act_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_REPORT,
      JMP_CHARGE
   } jmp_type;

   typedef logic [3:0] pc_type;

   localparam pc_type PC_ENTRY  = 4'd0;
   localparam pc_type PC_CHARGE = 4'd6;
   localparam pc_type PC_REPORT = 4'd7;

   typedef struct packed {
      a_sel_type a_sel;
      b_sel_type b_sel;
      logic      mul_en;
      act_type   act;
      jmp_type   jmp;
      pc_type    target;
      logic      last;
   } ucode_type;

   localparam ucode_type UC_NOP = '{
      a_sel: A_DRAIN, b_sel: B_LOAD100, mul_en: 1'b0, act: ACT_NONE,
      jmp: JMP_NONE, target: PC_ENTRY, last: 1'b0
   };

   // program rom: tick discharge 0..5, tick charge 0,1,6, report 0,7..12
   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      w = UC_NOP;
      unique case (pc)
         4'd0: begin
            w.a_sel = A_DRAIN;    w.b_sel = B_LOAD100; w.mul_en = 1'b1;
            w.jmp   = JMP_REPORT; w.target = PC_REPORT;
         end
         4'd1: begin
            w.a_sel = A_PROD_LOW; w.b_sel = B_GAIN;    w.mul_en = 1'b1;
            w.jmp   = JMP_CHARGE; w.target = PC_CHARGE;
         end
         4'd2: begin
            w.a_sel = A_SCALED;   w.b_sel = B_RECIP;   w.mul_en = 1'b1;
         end
         4'd3: begin
            w.a_sel = A_HEAT;     w.b_sel = B_LOAD1;   w.mul_en = 1'b1;
            w.act   = ACT_SAVE_DRAIN;
         end
         4'd4: begin
            w.a_sel = A_PROD_LOW; w.b_sel = B_RECIP;   w.mul_en = 1'b1;
         end
         4'd5: begin
            w.act = ACT_DISCHARGE; w.last = 1'b1;
         end
         4'd6: begin
            w.act = ACT_CHARGE;    w.last = 1'b1;
         end
         4'd7: begin
            w.a_sel = A_DIFF;     w.b_sel = B_SOC;     w.mul_en = 1'b1;
         end
         4'd8: begin
            w.a_sel = A_BIASED;   w.b_sel = B_RECIP;   w.mul_en = 1'b1;
         end
         4'd9: begin
            w.a_sel = A_TEMP;     w.b_sel = B_TEN;     w.mul_en = 1'b1;
            w.act   = ACT_SAVE_VOLT;
         end
         4'd10: w.act = ACT_EMIT_STATUS;
         4'd11: w.act = ACT_EMIT_TEMP;
         4'd12: begin
            w.act = ACT_EMIT_VOLT; w.last = 1'b1;
         end
         default: w.last = 1'b1;
      endcase
      return w;
   endfunction

endpackage

>>> sv/bctm_if.sv
// ----------------------------------------------------------------------------
// bctm channel interfaces
// Valid/ready channels for request words and response frames.
// ----------------------------------------------------------------------------
interface bctm_req_if import bctm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic              charger_connected;
   logic [LOAD_W-1:0] load_percent;

   modport source (output valid, req_type, charger_connected, load_percent,
                   input ready);
   modport sink   (input valid, req_type, charger_connected, load_percent,
                   output ready);
endinterface

interface bctm_rsp_if import bctm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ID_W-1:0]      frame_id;
   logic [PAYLOAD_W-1:0] payload;
   logic                 last_frame;

   modport source (output valid, frame_id, payload, last_frame, input ready);
   modport sink   (input valid, frame_id, payload, last_frame, output ready);
endinterface

>>> sv/battery_charge_thermal_model.sv
// ----------------------------------------------------------------------------
// battery_charge_thermal_model
// Fixed-point SOC and temperature model with CAN status frame reports.
// ----------------------------------------------------------------------------
// One request word is taken at a time and run by a 13-step microprogram on a
// single 33x33 multiplier with a registered product. A tick with the charger
// connected takes 3 steps, a discharging tick 6 (three multiplications and two
// divisions by 100 done as reciprocal multiplies), and a report 7 steps that
// end in three response words. Ready returns the cycle after the last step,
// so a new word is taken only once the last one is through; a stalled response
// path holds the report steps.
// Register writes are taken at any time and should be made while the block
// is idle. No clearing pass follows reset.
module battery_charge_thermal_model import bctm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bctm_req_if.sink              req_chan,
   bctm_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // ---- configuration registers ----
   logic [STEP_W-1:0] charge_step_ff, drain_step_ff, cool_step_ff, heat_step_ff;
   logic [VOLT_W-1:0] volt_floor_ff, volt_ceiling_ff;
   logic [GAIN_W-1:0] fault_gain_ff;
   logic              fault_on_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         charge_step_ff  <= CHARGE_STEP_RST;
         drain_step_ff   <= DRAIN_STEP_RST;
         cool_step_ff    <= COOL_STEP_RST;
         heat_step_ff    <= HEAT_STEP_RST;
         volt_floor_ff   <= VOLT_FLOOR_RST;
         volt_ceiling_ff <= VOLT_CEIL_RST;
         fault_gain_ff   <= GAIN_UNITY;
         fault_on_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CHARGE_STEP:  charge_step_ff  <= csr_wdata[STEP_W-1:0];
            CSR_DRAIN_STEP:   drain_step_ff   <= csr_wdata[STEP_W-1:0];
            CSR_COOL_STEP:    cool_step_ff    <= csr_wdata[STEP_W-1:0];
            CSR_HEAT_STEP:    heat_step_ff    <= csr_wdata[STEP_W-1:0];
            CSR_VOLT_FLOOR:   volt_floor_ff   <= csr_wdata[VOLT_W-1:0];
            CSR_VOLT_CEILING: volt_ceiling_ff <= csr_wdata[VOLT_W-1:0];
            CSR_FAULT_GAIN:   fault_gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_FAULT_ON:     fault_on_ff     <= csr_wdata[0];
         endcase
      end
   end

   // ---- sequencer ----
   logic              busy_ff;
   pc_type            pc_ff;
   logic              report_ff;
   logic [LOAD_W-1:0] load_ff;
   ucode_type         uc;
   logic              req_accept;
   logic              stall;
   logic              step_go;
   logic              jump_taken;
   logic              emit;
   logic              rsp_valid_ff;
   level_type         charge_level_ff, cell_temp_ff;
   logic              charging_flag_ff;

   assign uc         = ucode_rom(pc_ff);
   assign req_accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !busy_ff;
   assign emit       = (uc.act == ACT_EMIT_STATUS) || (uc.act == ACT_EMIT_TEMP) ||
                       (uc.act == ACT_EMIT_VOLT);
   // an emit step waits for the output register to free up
   assign stall      = emit && rsp_valid_ff && !rsp_chan.ready;
   assign step_go    = busy_ff && !stall;

   always_comb begin
      unique case (uc.jmp)
         JMP_NONE:   jump_taken = 1'b0;
         JMP_REPORT: jump_taken = report_ff;
         JMP_CHARGE: jump_taken = charging_flag_ff;
         default:    jump_taken = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= PC_ENTRY;
      end else if (req_accept) begin
         busy_ff <= 1'b1;
         pc_ff   <= PC_ENTRY;
      end else if (step_go) begin
         priority if (uc.last) begin
            busy_ff <= 1'b0;
         end else if (jump_taken) begin
            pc_ff <= uc.target;
         end else begin
            pc_ff <= pc_type'(pc_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         report_ff <= req_chan.req_type;
         load_ff   <= (req_chan.load_percent > LOAD_MAX[LOAD_W-1:0]) ?
                      LOAD_MAX[LOAD_W-1:0] : req_chan.load_percent;
      end
   end

   // ---- shared multiplier ----
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic        [16:0]       volt_span;
   logic        [23:0]       soc_scaled;
   logic        [31:0]       biased;
   logic        [7:0]        load100, load1;
   logic        [GAIN_W-1:0] gain;

   assign volt_span  = {1'b0, volt_ceiling_ff} - {1'b0, volt_floor_ff};
   assign soc_scaled = prod_ff[39:16];
   assign biased     = {{8{soc_scaled[23]}}, soc_scaled} + VOLT_BIAS;
   assign load100    = LOAD_MAX + {1'b0, load_ff};
   assign load1      = {1'b0, load_ff} + 8'd1;
   assign gain       = fault_on_ff ? fault_gain_ff : GAIN_UNITY;

   always_comb begin
      unique case (uc.a_sel)
         A_DRAIN:    mul_a = {{(MUL_W-STEP_W){1'b0}}, drain_step_ff};
         A_PROD_LOW: mul_a = {{(MUL_W-28){1'b0}}, prod_ff[27:0]};
         A_SCALED:   mul_a = {1'b0, prod_ff[39:8]};
         A_HEAT:     mul_a = {{(MUL_W-STEP_W){1'b0}}, heat_step_ff};
         A_DIFF:     mul_a = {{(MUL_W-17){volt_span[16]}}, volt_span};
         A_BIASED:   mul_a = {1'b0, biased};
         A_TEMP:     mul_a = {{(MUL_W-LEVEL_W){1'b0}}, cell_temp_ff};
         default:    mul_a = '0;
      endcase
      unique case (uc.b_sel)
         B_LOAD100:  mul_b = {{(MUL_W-8){1'b0}}, load100};
         B_GAIN:     mul_b = {{(MUL_W-GAIN_W){1'b0}}, gain};
         B_RECIP:    mul_b = {1'b0, RECIP};
         B_LOAD1:    mul_b = {{(MUL_W-8){1'b0}}, load1};
         B_SOC:      mul_b = {{(MUL_W-LEVEL_W){1'b0}}, charge_level_ff};
         B_TEN:      mul_b = {{(MUL_W-4){1'b0}}, 4'd10};
         default:    mul_b = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (step_go && uc.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // ---- model state ----
   logic [DRAIN_W-1:0]   drain_ff;
   logic [VOLT_W-1:0]    volt_ff;
   logic [HEAT_W-1:0]    heat;
   logic [23:0]          soc_sum, temp_sum, temp_less;
   level_type            soc_chg, soc_dis, temp_chg, temp_dis, temp_raw, temp_next;

   assign heat = prod_ff[QUOT_LSB+HEAT_W-1:QUOT_LSB];

   always_comb begin
      soc_sum   = {1'b0, charge_level_ff} + {{(24-STEP_W){1'b0}}, charge_step_ff};
      soc_chg   = (soc_sum > {1'b0, SOC_FULL}) ? SOC_FULL : soc_sum[LEVEL_W-1:0];
      soc_dis   = ({{(DRAIN_W-LEVEL_W){1'b0}}, charge_level_ff} <= drain_ff) ?
                  '0 : level_type'(charge_level_ff - drain_ff[LEVEL_W-1:0]);
      // cooling stops at the charge floor temperature
      temp_less = {1'b0, cell_temp_ff} - {{(24-STEP_W){1'b0}}, cool_step_ff};
      temp_chg  = (!temp_less[23] && (temp_less[LEVEL_W-1:0] > TEMP_COOL)) ?
                  temp_less[LEVEL_W-1:0] : TEMP_COOL;
      temp_sum  = {1'b0, cell_temp_ff} + {{(24-HEAT_W){1'b0}}, heat};
      temp_dis  = (temp_sum > {1'b0, TEMP_MAX}) ? TEMP_MAX : temp_sum[LEVEL_W-1:0];
      temp_raw  = (uc.act == ACT_CHARGE) ? temp_chg : temp_dis;
      priority if (temp_raw < TEMP_MIN) begin
         temp_next = TEMP_MIN;
      end else if (temp_raw > TEMP_MAX) begin
         temp_next = TEMP_MAX;
      end else begin
         temp_next = temp_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         charge_level_ff  <= SOC_FULL;
         cell_temp_ff     <= TEMP_INIT;
         charging_flag_ff <= 1'b0;
      end else begin
         if (req_accept && !req_chan.req_type) begin
            charging_flag_ff <= req_chan.charger_connected;
         end
         if (step_go && uc.act == ACT_CHARGE) begin
            charge_level_ff <= soc_chg;
            cell_temp_ff    <= temp_next;
         end else if (step_go && uc.act == ACT_DISCHARGE) begin
            charge_level_ff <= soc_dis;
            cell_temp_ff    <= temp_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && uc.act == ACT_SAVE_DRAIN) begin
         drain_ff <= prod_ff[QUOT_LSB+DRAIN_W-1:QUOT_LSB];
      end
      // bias drops out modulo 2^16
      if (step_go && uc.act == ACT_SAVE_VOLT) begin
         volt_ff <= volt_floor_ff + prod_ff[QUOT_LSB+VOLT_W-1:QUOT_LSB] -
                    VOLT_BIAS[VOLT_W-1:0];
      end
   end

   // ---- response register ----
   function automatic logic [PAYLOAD_W-1:0] two_bytes(input logic [15:0] v);
      return {{(PAYLOAD_W-16){1'b0}}, v[7:0], v[15:8]};
   endfunction

   logic [ID_W-1:0]      rsp_id_ff;
   logic [PAYLOAD_W-1:0] rsp_payload_ff;
   logic                 rsp_last_ff;
   logic [ID_W-1:0]      rsp_id_in;
   logic [PAYLOAD_W-1:0] rsp_payload_in;
   logic [15:0]          temp_tenths;

   assign temp_tenths = prod_ff[TEN_LSB+15:TEN_LSB];

   always_comb begin
      unique case (uc.act)
         ACT_EMIT_STATUS: begin
            rsp_id_in      = ID_STATUS;
            rsp_payload_in = {{(PAYLOAD_W-24){1'b0}}, 7'b0, fault_on_ff,
                              7'b0, charging_flag_ff,
                              1'b0, charge_level_ff[LEVEL_W-1:16]};
         end
         ACT_EMIT_TEMP: begin
            rsp_id_in      = ID_TEMP;
            rsp_payload_in = two_bytes(temp_tenths);
         end
         default: begin
            rsp_id_in      = ID_VOLT;
            rsp_payload_in = two_bytes(volt_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_go && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && emit) begin
         rsp_id_ff      <= rsp_id_in;
         rsp_payload_ff <= rsp_payload_in;
         rsp_last_ff    <= (uc.act == ACT_EMIT_VOLT);
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.frame_id   = rsp_id_ff;
   assign rsp_chan.payload    = rsp_payload_ff;
   assign rsp_chan.last_frame = rsp_last_ff;

   // ---- checks ----
   a_soc_range: assert property (@(posedge clock) disable iff (reset)
      charge_level_ff <= SOC_FULL)
      else $error("charge level above full");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      (cell_temp_ff >= TEMP_MIN) && (cell_temp_ff <= TEMP_MAX))
      else $error("cell temperature out of clamp range");

   a_last_is_volt: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.last_frame) |-> (rsp_chan.frame_id == ID_VOLT))
      else $error("last word of a report is not the voltage frame");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (busy_ff && pc_ff == PC_ENTRY))
      else $error("accepted word did not start the program");

endmodule

>>> test/tb_battery_charge_thermal_model.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_battery_charge_thermal_model
// Self-checking bench: a directed plan of register writes, ticks and reports
// is followed by random phases under several register settings. Every
// response frame is compared with the frames set in the plan or forecast by an
// in-bench model of the charge level, the cell temperature and the voltage map.
// ----------------------------------------------------------------------------
module tb_battery_charge_thermal_model;
   import bctm_pkg::*;

   localparam int unsigned SETTLE_CYCLES   = 16;
   localparam int unsigned HOLD_CYCLES     = 200;
   localparam int unsigned PHASES          = 6;
   localparam int unsigned ITEMS_PER_PHASE = 75;
   localparam int unsigned CYCLE_LIMIT     = 600000;
   localparam int unsigned REPORT_LIMIT    = 10;
   localparam int unsigned PLAN_LEN        = 34;

   typedef struct {
      logic [ID_W-1:0]      id;
      logic [PAYLOAD_W-1:0] data;
      logic                 last;
   } frame_type;

   typedef enum {ROW_SET, ROW_TICK, ROW_REPORT} plan_kind_type;

   typedef struct {
      plan_kind_type     kind;
      csr_index_type     reg_idx;
      logic [19:0]       value;
      logic              chg;
      logic [LOAD_W-1:0] load;
      logic              typed;
      logic [63:0]       status;
      logic [63:0]       temp;
      logic [63:0]       volt;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bctm_req_if req_if ();
   bctm_rsp_if rsp_if ();

   battery_charge_thermal_model dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // model state and register copies
   bit [LEVEL_W-1:0] soc_level;
   bit [LEVEL_W-1:0] cell_heat;
   bit               chg_flag;
   bit [STEP_W-1:0]  chg_step, drn_step, cool_amt, heat_amt;
   bit [VOLT_W-1:0]  v_floor, v_ceil;
   bit [GAIN_W-1:0]  f_gain;
   bit               f_on;

   frame_type   pending_frames[$];
   int unsigned mismatches;
   int unsigned cycles;
   bit          sender_idles;
   bit          receiver_idles;
   logic        hold_pending;

   plan_row_type plan [PLAN_LEN] = '{
      // straight after reset: 100 %, 25.0 C, 420.0 V
      '{ROW_REPORT, CSR_CHARGE_STEP, 20'd0, 1'b0, 7'd0, 1'b1,
        64'h64, 64'hFA00, 64'h6810},
      '{ROW_TICK, CSR_CHARGE_STEP, 20'd0, 1'b0, 7'd0, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_TICK, CSR_CHARGE_STEP, 20'd0, 1'b0, 7'd100, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_TICK, CSR_CHARGE_STEP, 20'd0, 1'b0, 7'd127, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_TICK, CSR_CHARGE_STEP, 20'd0, 1'b1, 7'd55, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_REPORT, CSR_CHARGE_STEP, 20'd0, 1'b0, 7'd0, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_SET, CSR_DRAIN_STEP, 20'hFFFFF, 1'b0, 7'd0, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_SET, CSR_HEAT_STEP, 20'hFFFFF, 1'b0, 7'd0, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_TICK, CSR_CHARGE_STEP, 20'd0, 1'b0, 7'd127, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_TICK, CSR_CHARGE_STEP, 20'd0, 1'b0, 7'd127, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_TICK, CSR_CHARGE_STEP, 20'd0, 1'b0, 7'd100, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_TICK, CSR_CHARGE_STEP, 20'd0, 1'b0, 7'd127, 1'b0, 64'd0, 64'd0, 64'd0},
      // empty and at the 80 C ceiling, voltage at the floor
      '{ROW_REPORT, CSR_CHARGE_STEP, 20'd0, 1'b1, 7'd0, 1'b1,
        64'h0, 64'h2003, 64'hF00A},
      '{ROW_SET, CSR_CHARGE_STEP, 20'hFFFFF, 1'b0, 7'd0, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_SET, CSR_COOL_STEP, 20'hFFFFF, 1'b0, 7'd0, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_TICK, CSR_CHARGE_STEP, 20'd0, 1'b1, 7'd0, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_TICK, CSR_CHARGE_STEP, 20'd0, 1'b1, 7'd127, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_TICK, CSR_CHARGE_STEP, 20'd0, 1'b1, 7'd64, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_TICK, CSR_CHARGE_STEP, 20'd0, 1'b1, 7'd1, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_REPORT, CSR_CHARGE_STEP, 20'd0, 1'b0, 7'd0, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_SET, CSR_FAULT_GAIN, 20'hFFFFF, 1'b0, 7'd0, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_SET, CSR_FAULT_ON, 20'd1, 1'b0, 7'd0, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_TICK, CSR_CHARGE_STEP, 20'd0, 1'b0, 7'd50, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_REPORT, CSR_CHARGE_STEP, 20'd0, 1'b0, 7'd0, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_SET, CSR_FAULT_GAIN, 20'd0, 1'b0, 7'd0, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_TICK, CSR_CHARGE_STEP, 20'd0, 1'b1, 7'd3, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_TICK, CSR_CHARGE_STEP, 20'd0, 1'b0, 7'd100, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_REPORT, CSR_CHARGE_STEP, 20'd0, 1'b1, 7'd127, 1'b0, 64'd0, 64'd0, 64'd0},
      // ceiling under floor: map falls with charge
      '{ROW_SET, CSR_VOLT_FLOOR, 20'hFFFFF, 1'b0, 7'd0, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_SET, CSR_VOLT_CEILING, 20'd0, 1'b0, 7'd0, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_REPORT, CSR_CHARGE_STEP, 20'd0, 1'b0, 7'd0, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_SET, CSR_VOLT_FLOOR, 20'd0, 1'b0, 7'd0, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_SET, CSR_VOLT_CEILING, 20'hFFFF, 1'b0, 7'd0, 1'b0, 64'd0, 64'd0, 64'd0},
      '{ROW_REPORT, CSR_CHARGE_STEP, 20'd0, 1'b0, 7'd0, 1'b0, 64'd0, 64'd0, 64'd0}
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model

   task automatic advance_charge(input logic chg, input logic [LOAD_W-1:0] load);
      bit [63:0] ld, gain, drain, heat, sum;
      ld = (load > 100) ? 64'd100 : 64'(load);
      chg_flag = chg;
      if (chg) begin
         sum = 64'(soc_level) + 64'(chg_step);
         soc_level = (sum > 64'(SOC_FULL)) ? SOC_FULL : sum[LEVEL_W-1:0];
         if (cell_heat >= cool_amt && cell_heat - cool_amt > TEMP_COOL)
            cell_heat = cell_heat - cool_amt;
         else
            cell_heat = TEMP_COOL;
      end else begin
         gain  = f_on ? 64'(f_gain) : 64'd256;
         drain = 64'(drn_step) * (64'd100 + ld) * gain / 64'd25600;
         heat  = 64'(heat_amt) * (ld + 64'd1) / 64'd100;
         soc_level = (drain >= 64'(soc_level)) ? '0 : soc_level - drain[LEVEL_W-1:0];
         sum = 64'(cell_heat) + heat;
         cell_heat = (sum > 64'(TEMP_MAX)) ? TEMP_MAX : sum[LEVEL_W-1:0];
      end
      if (cell_heat < TEMP_MIN) cell_heat = TEMP_MIN;
      if (cell_heat > TEMP_MAX) cell_heat = TEMP_MAX;
   endtask

   function automatic logic [63:0] byte_swapped(input bit [15:0] v);
      return {48'd0, v[7:0], v[15:8]};
   endfunction

   task automatic queue_frame(input logic [ID_W-1:0] id, input logic [63:0] data,
                              input logic last);
      frame_type f;
      f.id   = id;
      f.data = data;
      f.last = last;
      pending_frames.push_back(f);
   endtask

   task automatic forecast_report();
      longint    diff, num, q, full;
      bit [63:0] t10;
      bit [15:0] volts;
      full = longint'(SOC_FULL);
      diff = longint'(v_ceil) - longint'(v_floor);
      num  = diff * longint'(soc_level);
      // voltage map rounds toward minus infinity
      if (num >= 0)
         q = num / full;
      else
         q = -((-num + full - 1) / full);
      volts = v_floor + q[15:0];
      t10 = (64'(cell_heat) * 64'd10) >> 16;
      queue_frame(ID_STATUS, {40'd0, 7'd0, f_on, 7'd0, chg_flag, 1'b0,
                              soc_level[LEVEL_W-1:16]}, 1'b0);
      queue_frame(ID_TEMP, byte_swapped(t10[15:0]), 1'b0);
      queue_frame(ID_VOLT, byte_swapped(volts), 1'b1);
   endtask

   // ------------------------------------------------------------- response

   task automatic check_frame(input frame_type got);
      frame_type want;
      if (pending_frames.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("unexpected frame: id %h payload %h last %b",
                     got.id, got.data, got.last);
      end else begin
         want = pending_frames.pop_front();
         if (got.id !== want.id || got.data !== want.data || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("frame mismatch: expected id %h payload %h last %b, got %h %h %b",
                        want.id, want.data, want.last, got.id, got.data, got.last);
         end
      end
   endtask

   function automatic int unsigned pick_gap(input bit on);
      int unsigned r;
      if (!on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   initial begin : response_side
      int unsigned stall_left;
      int unsigned g;
      frame_type   got;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            got.id   = rsp_if.frame_id;
            got.data = rsp_if.payload;
            got.last = rsp_if.last_frame;
            check_frame(got);
         end
         // long hold-off so that the block backs up onto its input
         if (hold_pending) begin
            stall_left = HOLD_CYCLES;
            hold_pending <= 1'b0;
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            g = pick_gap(receiver_idles);
            if (g == 0) begin
               rsp_if.ready <= 1'b1;
            end else begin
               rsp_if.ready <= 1'b0;
               stall_left = g - 1;
            end
         end
      end
   end

   // ------------------------------------------------------------- stimulus

   // called at a rising edge; returns at the edge that takes the word
   task automatic send_word(input logic rt, input logic chg,
                            input logic [LOAD_W-1:0] load, input int unsigned gap);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid             <= 1'b1;
      req_if.req_type          <= rt;
      req_if.charger_connected <= chg;
      req_if.load_percent      <= load;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      // ticks leave no frame behind, so give the last one time to finish
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [19:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_CHARGE_STEP:  chg_step = value;
         CSR_DRAIN_STEP:   drn_step = value;
         CSR_COOL_STEP:    cool_amt = value;
         CSR_HEAT_STEP:    heat_amt = value;
         CSR_VOLT_FLOOR:   v_floor  = value[VOLT_W-1:0];
         CSR_VOLT_CEILING: v_ceil   = value[VOLT_W-1:0];
         CSR_FAULT_GAIN:   f_gain   = value[GAIN_W-1:0];
         CSR_FAULT_ON:     f_on     = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [19:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r < 5) return 20'($urandom_range(0, 8191));
      return 20'($urandom);
   endfunction

   task automatic run_word(input logic rt, input logic chg, input logic [LOAD_W-1:0] load);
      send_word(rt, chg, load, pick_gap(sender_idles));
      if (rt)
         forecast_report();
      else
         advance_charge(chg, load);
   endtask

   initial begin : stimulus
      bit            writing;
      logic          rt, chg;
      logic [19:0]   v;
      logic [LOAD_W-1:0] load;

      clock                    = 1'b0;
      reset                    = 1'b1;
      csr_we                   = 1'b0;
      csr_index                = CSR_CHARGE_STEP;
      csr_wdata                = '0;
      req_if.valid             = 1'b0;
      req_if.req_type          = 1'b0;
      req_if.charger_connected = 1'b0;
      req_if.load_percent      = '0;
      hold_pending             = 1'b0;
      mismatches               = 0;
      cycles                   = 0;
      sender_idles             = 1'b1;
      receiver_idles           = 1'b1;

      chg_step  = CHARGE_STEP_RST;
      drn_step  = DRAIN_STEP_RST;
      cool_amt  = COOL_STEP_RST;
      heat_amt  = HEAT_STEP_RST;
      v_floor   = VOLT_FLOOR_RST;
      v_ceil    = VOLT_CEIL_RST;
      f_gain    = GAIN_UNITY;
      f_on      = 1'b0;
      soc_level = SOC_FULL;
      cell_heat = TEMP_INIT;
      chg_flag  = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed plan
      writing = 1'b0;
      for (int r = 0; r < PLAN_LEN; r++) begin
         if (plan[r].kind == ROW_SET) begin
            if (!writing) settle();
            write_reg(plan[r].reg_idx, plan[r].value);
            writing = 1'b1;
         end else begin
            if (writing) begin
               csr_we <= 1'b0;
               writing = 1'b0;
            end
            rt = (plan[r].kind == ROW_REPORT);
            if (rt && plan[r].typed) begin
               send_word(rt, plan[r].chg, plan[r].load, pick_gap(sender_idles));
               queue_frame(ID_STATUS, plan[r].status, 1'b0);
               queue_frame(ID_TEMP, plan[r].temp, 1'b0);
               queue_frame(ID_VOLT, plan[r].volt, 1'b1);
            end else begin
               run_word(rt, plan[r].chg, plan[r].load);
            end
         end
      end

      // random phases, each under its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         for (int i = 0; i < 8; i++) begin
            if (ph == 3)
               v = '1;
            else if (ph == 4)
               v = '0;
            else
               v = pick_value();
            write_reg(csr_index_type'(i), v);
         end
         csr_we <= 1'b0;
         sender_idles   = (ph != 0 && ph != 2);
         receiver_idles = (ph != 0 && ph != 2);
         if (ph == 2) hold_pending <= 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            rt   = ($urandom_range(0, 99) < 40);
            chg  = 1'($urandom_range(0, 1));
            load = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(101, 127))
                                               : 7'($urandom_range(0, 100));
            run_word(rt, chg, load);
         end
      end

      settle();
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
